// ===== hw/rtl/ctt_pkg.sv =====
// Package for the configuration text tokenizer.
// Token kinds, character codes, queue entry types and offset helpers.
// No dependencies; used by every module of the block.
`default_nettype none

package ctt_pkg;

	// Text length that offsets wrap at
	localparam int MAX_TEXT_BYTES = 65536;
	localparam int POS_W          = $clog2(MAX_TEXT_BYTES);

	// Tokens one item can give, and queue size
	localparam int TOK_MAX     = 3;
	localparam int CNT_W       = $clog2(TOK_MAX + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [3:0] {
		TK_IDENT  = 4'd0,
		TK_ASSIGN = 4'd1,
		TK_DOT    = 4'd2,
		TK_COMMA  = 4'd3,
		TK_STRING = 4'd4,
		TK_LBRACE = 4'd5,
		TK_RBRACE = 4'd6,
		TK_LPAREN = 4'd7,
		TK_RPAREN = 4'd8,
		TK_GT     = 4'd9,
		TK_END    = 4'd10,
		TK_BAD    = 4'd11,
		TK_UNTERM = 4'd12
	} token_kind_t;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_USCR  = 8'h5F;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	typedef struct packed {
		token_kind_t kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic [7:0]  bad;
	} tok_t;

	// One queue entry: all tokens caused by one item
	typedef struct packed {
		logic [CNT_W-1:0]         cnt;
		tok_t [TOK_MAX-1:0]       tok;
	} entry_t;

	// Offset plus one, wrapping at the text size
	function automatic pos_t pos_next(input pos_t p);
		pos_t r;
		if (p == POS_W'(MAX_TEXT_BYTES - 1)) begin
			r = '0;
		end else begin
			r = p + POS_W'(1);
		end
		return r;
	endfunction

	// Distance from t up to p, modulo the text size
	function automatic pos_t span(input pos_t p, input pos_t t);
		logic [POS_W:0] d;
		d = {1'b0, p} - {1'b0, t};
		if (p < t) begin
			d = d + (POS_W+1)'(MAX_TEXT_BYTES);
		end
		return d[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/config_text_tokenizer.sv =====
// Top level of the configuration text tokenizer.
// Instantiates ctt_front, ctt_queue and ctt_back; uses ctt_pkg.
//
//  channel   handshake                 payload
//  item      item_valid / item_ready   char_byte, byte_present, end_of_input
//  token     token_valid / token_ready token_kind, content_offset, content_length,
//                                      line_number, offending_byte, last_of_run
//
// An item is taken every cycle while the four-entry token queue has room.
// Tokens leave one per cycle while token_ready is high; the first token of an item
// passes through a queue slot and then the output register.
// Reset clears scan state, queue pointers and output valid at once.
// Either side may stall without blocking the other until the queue fills.
`default_nettype none

module config_text_tokenizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  char_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_input,
	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [3:0]       token_kind,
	output logic [15:0]      content_offset,
	output logic [15:0]      content_length,
	output logic [15:0]      line_number,
	output logic [7:0]       offending_byte,
	output logic             last_of_run
);

	logic             q_full, q_empty, q_push, q_pop;
	ctt_pkg::entry_t  q_in, q_head;

	ctt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.char_byte    (char_byte),
		.byte_present (byte_present),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.push         (q_push),
		.push_data    (q_in)
	);

	ctt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	ctt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.empty          (q_empty),
		.pop            (q_pop),
		.token_valid    (token_valid),
		.token_ready    (token_ready),
		.token_kind     (token_kind),
		.content_offset (content_offset),
		.content_length (content_length),
		.line_number    (line_number),
		.offending_byte (offending_byte),
		.last_of_run    (last_of_run)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ctt_front.sv =====
// Front end of the tokenizer: accepts text items, tracks scan state and
// gathers the tokens of each item into one queue entry. Uses ctt_pkg.
`default_nettype none

module ctt_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire logic [7:0]      char_byte,
	input  wire logic            byte_present,
	input  wire logic            end_of_input,
	input  wire logic            q_full,
	output logic                 push,
	output ctt_pkg::entry_t      push_data
);

	typedef enum logic [2:0] {
		M_IDLE   = 3'b001,
		M_IDENT  = 3'b010,
		M_STRING = 3'b100
	} mode_t;

	mode_t             mode_q, mode_n;
	ctt_pkg::pos_t     start_q, start_n;
	ctt_pkg::pos_t     pos_q, pos_n;
	logic [15:0]       line_q, line_n;

	logic              accept, consume, finish;
	logic              is_ident, is_quote, is_nl, is_punct;
	ctt_pkg::token_kind_t punct_kind;
	logic              do_idle, bump;
	mode_t             mode1;
	ctt_pkg::pos_t     start1, pos1;
	logic [15:0]       line1;

	// Four candidate tokens in emission order
	logic [3:0]        cv;
	ctt_pkg::tok_t     ct [4];

	assign accept     = item_valid && item_ready;
	assign item_ready = !q_full;
	assign consume    = byte_present && (char_byte != ctt_pkg::CH_NUL);
	assign finish     = end_of_input || (byte_present && (char_byte == ctt_pkg::CH_NUL));

	// Byte classes
	always_comb begin
		is_ident = char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
			ctt_pkg::CH_USCR};
		is_quote = (char_byte == ctt_pkg::CH_QUOTE);
		is_nl    = (char_byte == ctt_pkg::CH_NL);
		is_punct = 1'b1;
		case (char_byte)
			ctt_pkg::CH_LBRC:  punct_kind = ctt_pkg::TK_LBRACE;
			ctt_pkg::CH_RBRC:  punct_kind = ctt_pkg::TK_RBRACE;
			ctt_pkg::CH_EQ:    punct_kind = ctt_pkg::TK_ASSIGN;
			ctt_pkg::CH_GT:    punct_kind = ctt_pkg::TK_GT;
			ctt_pkg::CH_DOT:   punct_kind = ctt_pkg::TK_DOT;
			ctt_pkg::CH_COMMA: punct_kind = ctt_pkg::TK_COMMA;
			ctt_pkg::CH_LPAR:  punct_kind = ctt_pkg::TK_LPAREN;
			ctt_pkg::CH_RPAR:  punct_kind = ctt_pkg::TK_RPAREN;
			default: begin
				punct_kind = ctt_pkg::TK_BAD;
				is_punct   = 1'b0;
			end
		endcase
	end

	// Byte handling and end of text
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cv[i] = 1'b0;
			ct[i] = '{kind: ctt_pkg::TK_END, offset: '0, length: '0, line: line_q, bad: '0};
		end
		mode1   = mode_q;
		start1  = start_q;
		pos1    = pos_q;
		do_idle = 1'b0;
		bump    = 1'b0;

		if (consume) begin
			pos1 = ctt_pkg::pos_next(pos_q);
			case (mode_q)
				M_STRING: begin
					if (is_quote) begin
						cv[0]        = 1'b1;
						ct[0].kind   = ctt_pkg::TK_STRING;
						ct[0].offset = 16'(start_q);
						ct[0].length = 16'(ctt_pkg::span(pos_q, start_q));
						mode1        = M_IDLE;
					end else if (is_nl) begin
						bump = 1'b1;
					end
				end
				M_IDENT: begin
					if (!is_ident) begin
						cv[0]        = 1'b1;
						ct[0].kind   = ctt_pkg::TK_IDENT;
						ct[0].offset = 16'(start_q);
						ct[0].length = 16'(ctt_pkg::span(pos_q, start_q));
						mode1        = M_IDLE;
						do_idle      = 1'b1;
					end
				end
				default: begin
					mode1   = M_IDLE;
					do_idle = 1'b1;
				end
			endcase

			// Byte seen with no token open
			if (do_idle) begin
				if (is_punct) begin
					cv[1]        = 1'b1;
					ct[1].kind   = punct_kind;
					ct[1].offset = 16'(pos_q);
				end else if (is_quote) begin
					mode1  = M_STRING;
					start1 = ctt_pkg::pos_next(pos_q);
				end else if (is_nl) begin
					bump = 1'b1;
				end else if (is_ident) begin
					mode1  = M_IDENT;
					start1 = pos_q;
				end else if (!(char_byte inside {ctt_pkg::CH_SPACE, ctt_pkg::CH_CR,
						ctt_pkg::CH_TAB})) begin
					cv[1]        = 1'b1;
					ct[1].kind   = ctt_pkg::TK_BAD;
					ct[1].offset = 16'(pos_q);
					ct[1].bad    = char_byte;
				end
			end
		end

		line1 = (bump && line_q != ctt_pkg::LINE_MAX) ? line_q + 16'd1 : line_q;

		// End of text closes what is open, then the end token
		if (finish) begin
			if (mode1 == M_IDENT || mode1 == M_STRING) begin
				cv[2]        = 1'b1;
				ct[2].kind   = (mode1 == M_IDENT) ? ctt_pkg::TK_IDENT : ctt_pkg::TK_UNTERM;
				ct[2].offset = 16'(start1);
				ct[2].length = 16'(ctt_pkg::span(pos1, start1));
				ct[2].line   = line1;
			end
			cv[3]        = 1'b1;
			ct[3].kind   = ctt_pkg::TK_END;
			ct[3].offset = 16'(pos1);
			ct[3].line   = line1;
		end
	end

	// Pack present candidates into the entry
	always_comb begin
		logic [1:0] n;
		n = 2'd0;
		push_data.cnt = '0;
		for (int i = 0; i < ctt_pkg::TOK_MAX; i++) begin
			push_data.tok[i] = ct[3];
		end
		for (int i = 0; i < 4; i++) begin
			if (cv[i] && n != 2'd3) begin
				push_data.tok[n] = ct[i];
				n = n + 2'd1;
			end
		end
		push_data.cnt = ctt_pkg::CNT_W'(n);
	end

	assign push = accept && (cv != 4'd0);

	// Next state
	always_comb begin
		mode_n  = mode1;
		start_n = start1;
		pos_n   = pos1;
		line_n  = line1;
		if (finish) begin
			mode_n  = M_IDLE;
			start_n = '0;
			pos_n   = '0;
			line_n  = 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			start_q <= '0;
			pos_q   <= '0;
			line_q  <= 16'd1;
		end else if (accept) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			pos_q   <= pos_n;
			line_q  <= line_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ctt_queue.sv =====
// Short queue of token entries between front and back end.
// Show-ahead head output. Uses ctt_pkg.
`default_nettype none

module ctt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ctt_pkg::entry_t  push_data,
	output logic                  full,
	input  wire logic             pop,
	output ctt_pkg::entry_t       head,
	output logic                  empty
);

	ctt_pkg::entry_t              slot_q [ctt_pkg::QUEUE_DEPTH];
	logic [ctt_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [ctt_pkg::QPTR_W:0]     count_q;

	function automatic logic [ctt_pkg::QPTR_W-1:0] ptr_next(
		input logic [ctt_pkg::QPTR_W-1:0] p);
		logic [ctt_pkg::QPTR_W-1:0] r;
		if (p == ctt_pkg::QPTR_W'(ctt_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + ctt_pkg::QPTR_W'(1);
		end
		return r;
	endfunction

	assign full  = (count_q == (ctt_pkg::QPTR_W+1)'(ctt_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop && !empty) begin
				rd_q <= ptr_next(rd_q);
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ctt_back.sv =====
// Back end of the tokenizer: walks the tokens of the head queue entry
// and presents them one per cycle while token_ready is high, in an output register. Uses ctt_pkg.
`default_nettype none

module ctt_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctt_pkg::entry_t  head,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  token_valid,
	input  wire logic             token_ready,
	output logic [3:0]            token_kind,
	output logic [15:0]           content_offset,
	output logic [15:0]           content_length,
	output logic [15:0]           line_number,
	output logic [7:0]            offending_byte,
	output logic                  last_of_run
);

	logic [1:0]     idx_q;
	logic           valid_q;
	ctt_pkg::tok_t  tok_q;
	logic           last_q;
	logic           load, is_last;

	assign load    = !empty && (!valid_q || token_ready);
	assign is_last = (ctt_pkg::CNT_W'(idx_q) + ctt_pkg::CNT_W'(1)) == head.cnt;
	assign pop     = load && is_last;

	// Token index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (token_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head.tok[idx_q];
			last_q <= is_last;
		end
	end

	assign token_valid    = valid_q;
	assign token_kind     = tok_q.kind;
	assign content_offset = tok_q.offset;
	assign content_length = tok_q.length;
	assign line_number    = tok_q.line;
	assign offending_byte = tok_q.bad;
	assign last_of_run    = last_q;

endmodule

`default_nettype wire

// ===== tb/config_text_tokenizer_test.sv =====
// Self-checking testbench for config_text_tokenizer: directed table, then random text.
// Expected tokens come from a behavioural tokenizer kept alongside the DUT.
// Depends on ctt_pkg and config_text_tokenizer.
`timescale 1ns / 1ps

module config_text_tokenizer_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_ITEMS   = 170;
	localparam int DRAIN_CYCLES   = 16;
	localparam int REPORT_LIMIT   = 60;

	typedef enum logic [1:0] {
		SCAN_IDLE   = 2'd0,
		SCAN_IDENT  = 2'd1,
		SCAN_STRING = 2'd2
	} scan_mode_t;

	typedef struct packed {
		ctt_pkg::token_kind_t kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic [7:0]  bad;
		logic        last;
	} token_rec_t;

	typedef struct {
		logic [7:0] c;
		logic       p;
		logic       e;
		bit         pinned;
		token_rec_t pin;
	} text_row_t;

	logic        clk            = 1'b0;
	logic        arst_n;
	logic        item_valid     = 1'b0;
	logic        item_ready;
	logic [7:0]  char_byte      = 8'h00;
	logic        byte_present   = 1'b0;
	logic        end_of_input   = 1'b0;
	logic        token_valid;
	logic        token_ready    = 1'b0;
	logic [3:0]  token_kind;
	logic [15:0] content_offset;
	logic [15:0] content_length;
	logic [15:0] line_number;
	logic [7:0]  offending_byte;
	logic        last_of_run;

	// Shared between the sender and the token sink; quiet_cycles is the watchdog's
	token_rec_t  expected_tokens[$];
	int          mismatches    = 0;
	int          hold_requests = 0;
	bit          steady_flow   = 1'b0;
	int          quiet_cycles  = 0;

	// Behavioural tokenizer state
	scan_mode_t     scan_mode_m;
	ctt_pkg::pos_t  span_start_m;
	ctt_pkg::pos_t  text_pos_m;
	logic [15:0]    line_m;
	token_rec_t     run_tokens[$];

	text_row_t   text_table[$];

	config_text_tokenizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.char_byte     (char_byte),
		.byte_present  (byte_present),
		.end_of_input  (end_of_input),
		.token_valid   (token_valid),
		.token_ready   (token_ready),
		.token_kind    (token_kind),
		.content_offset(content_offset),
		.content_length(content_length),
		.line_number   (line_number),
		.offending_byte(offending_byte),
		.last_of_run   (last_of_run)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Tokenizer model
	// ---------------------------------------------------------------
	function automatic bit ident_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == ctt_pkg::CH_USCR;
	endfunction

	task automatic push_token(input ctt_pkg::token_kind_t kind, input ctt_pkg::pos_t off,
			input ctt_pkg::pos_t len, input logic [7:0] bad);
		token_rec_t t;
		t.kind   = kind;
		t.offset = off;
		t.length = len;
		t.line   = line_m;
		t.bad    = bad;
		t.last   = 1'b0;
		run_tokens.push_back(t);
	endtask

	task automatic bump_line();
		if (line_m != ctt_pkg::LINE_MAX) begin
			line_m = line_m + 16'd1;
		end
	endtask

	// Byte seen with no token open
	task automatic idle_char(input logic [7:0] c);
		case (c)
			ctt_pkg::CH_LBRC:  push_token(ctt_pkg::TK_LBRACE, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_RBRC:  push_token(ctt_pkg::TK_RBRACE, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_EQ:    push_token(ctt_pkg::TK_ASSIGN, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_GT:    push_token(ctt_pkg::TK_GT, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_DOT:   push_token(ctt_pkg::TK_DOT, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_COMMA: push_token(ctt_pkg::TK_COMMA, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_LPAR:  push_token(ctt_pkg::TK_LPAREN, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_RPAR:  push_token(ctt_pkg::TK_RPAREN, text_pos_m, '0, 8'h00);
			ctt_pkg::CH_QUOTE: begin
				scan_mode_m  = SCAN_STRING;
				span_start_m = text_pos_m + ctt_pkg::pos_t'(1);
			end
			ctt_pkg::CH_SPACE, ctt_pkg::CH_CR, ctt_pkg::CH_TAB: ;
			ctt_pkg::CH_NL:    bump_line();
			default: begin
				if (ident_char(c)) begin
					scan_mode_m  = SCAN_IDENT;
					span_start_m = text_pos_m;
				end else begin
					push_token(ctt_pkg::TK_BAD, text_pos_m, '0, c);
				end
			end
		endcase
	endtask

	// One consumed byte; offsets wrap naturally at 16 bits
	task automatic take_char(input logic [7:0] c);
		if (scan_mode_m == SCAN_STRING) begin
			if (c == ctt_pkg::CH_QUOTE) begin
				push_token(ctt_pkg::TK_STRING, span_start_m, text_pos_m - span_start_m,
					8'h00);
				scan_mode_m = SCAN_IDLE;
			end else if (c == ctt_pkg::CH_NL) begin
				bump_line();
			end
		end else if (!(scan_mode_m == SCAN_IDENT && ident_char(c))) begin
			if (scan_mode_m == SCAN_IDENT) begin
				push_token(ctt_pkg::TK_IDENT, span_start_m, text_pos_m - span_start_m,
					8'h00);
			end
			scan_mode_m = SCAN_IDLE;
			idle_char(c);
		end
		text_pos_m = text_pos_m + ctt_pkg::pos_t'(1);
	endtask

	task automatic close_text();
		if (scan_mode_m == SCAN_IDENT) begin
			push_token(ctt_pkg::TK_IDENT, span_start_m, text_pos_m - span_start_m, 8'h00);
		end else if (scan_mode_m == SCAN_STRING) begin
			push_token(ctt_pkg::TK_UNTERM, span_start_m, text_pos_m - span_start_m, 8'h00);
		end
		push_token(ctt_pkg::TK_END, text_pos_m, '0, 8'h00);
		scan_mode_m  = SCAN_IDLE;
		span_start_m = '0;
		text_pos_m   = '0;
		line_m       = 16'd1;
	endtask

	// Tokens caused by one item, left in run_tokens
	task automatic tokenize_item(input logic [7:0] c, input logic p, input logic e);
		logic ending;
		ending = e;
		run_tokens.delete();
		if (p) begin
			if (c == ctt_pkg::CH_NUL) begin
				ending = 1'b1;
			end else begin
				take_char(c);
			end
		end
		if (ending) begin
			close_text();
		end
		if (run_tokens.size() > 0) begin
			run_tokens[run_tokens.size() - 1].last = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offer one item, record its tokens on acceptance, then maybe idle
	task automatic offer(input logic [7:0] c, input logic p, input logic e, input bit pinned,
			input token_rec_t pin);
		int gap;
		item_valid   <= 1'b1;
		char_byte    <= c;
		byte_present <= p;
		end_of_input <= e;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		tokenize_item(c, p, e);
		if (pinned && run_tokens.size() > 0) begin
			pin.last      = run_tokens[0].last;
			run_tokens[0] = pin;
		end
		foreach (run_tokens[i]) begin
			expected_tokens.push_back(run_tokens[i]);
		end
		gap = steady_flow ? 0 : idle_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic offer_plain(input logic [7:0] c, input logic p, input logic e);
		token_rec_t none;
		none = '0;
		offer(c, p, e, 1'b0, none);
	endtask

	// Hold the sender until every outstanding token is out
	task automatic drain();
		if (expected_tokens.size() != 0) begin
			item_valid <= 1'b0;
			while (expected_tokens.size() != 0) begin
				@(posedge clk);
			end
		end
	endtask

	task automatic plain_row(input logic [7:0] c, input logic p, input logic e);
		text_row_t r;
		r.c      = c;
		r.p      = p;
		r.e      = e;
		r.pinned = 1'b0;
		r.pin    = '0;
		text_table.push_back(r);
	endtask

	task automatic pinned_row(input logic [7:0] c, input logic p, input logic e,
			input ctt_pkg::token_kind_t kind, input logic [15:0] off, input logic [15:0] len,
			input logic [15:0] line, input logic [7:0] bad);
		text_row_t r;
		r.c          = c;
		r.p          = p;
		r.e          = e;
		r.pinned     = 1'b1;
		r.pin.kind   = kind;
		r.pin.offset = off;
		r.pin.length = len;
		r.pin.line   = line;
		r.pin.bad    = bad;
		r.pin.last   = 1'b0;
		text_table.push_back(r);
	endtask

	function automatic logic [7:0] punct_byte();
		case ($urandom_range(0, 7))
			0:       return ctt_pkg::CH_LBRC;
			1:       return ctt_pkg::CH_RBRC;
			2:       return ctt_pkg::CH_EQ;
			3:       return ctt_pkg::CH_GT;
			4:       return ctt_pkg::CH_DOT;
			5:       return ctt_pkg::CH_COMMA;
			6:       return ctt_pkg::CH_LPAR;
			default: return ctt_pkg::CH_RPAR;
		endcase
	endfunction

	// Mostly well-formed text with random content, some noise and broken input
	task automatic random_item(output logic [7:0] c, output logic p, output logic e,
			output bit counted);
		string ident_set;
		int    r;
		ident_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
		r         = $urandom_range(0, 99);
		p         = 1'b1;
		e         = ($urandom_range(0, 49) == 0);
		counted   = 1'b1;
		if (r < 38) begin
			c = ident_set[$urandom_range(0, 62)];
		end else if (r < 54) begin
			c = punct_byte();
		end else if (r < 64) begin
			case ($urandom_range(0, 2))
				0:       c = ctt_pkg::CH_SPACE;
				1:       c = ctt_pkg::CH_TAB;
				default: c = ctt_pkg::CH_CR;
			endcase
		end else if (r < 71) begin
			c = ctt_pkg::CH_NL;
		end else if (r < 80) begin
			c = ctt_pkg::CH_QUOTE;
		end else if (r < 87) begin
			c = 8'($urandom_range(0, 255));
		end else if (r < 89) begin
			c = ctt_pkg::CH_NUL;
		end else if (r < 95) begin
			// no byte, no end: ignored by the block
			c       = 8'($urandom_range(0, 255));
			p       = 1'b0;
			e       = 1'b0;
			counted = 1'b0;
		end else begin
			c = 8'($urandom_range(0, 255));
			p = 1'b0;
			e = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		logic [7:0] c;
		logic       p;
		logic       e;
		bit         counted;
		int         sent;

		arst_n       <= 1'b0;
		scan_mode_m  = SCAN_IDLE;
		span_start_m = '0;
		text_pos_m   = '0;
		line_m       = 16'd1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text
		pinned_row(ctt_pkg::CH_LBRC, 1'b1, 1'b0, ctt_pkg::TK_LBRACE, 16'd0, 16'd0, 16'd1,
			8'h00);
		plain_row("A", 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_USCR, 1'b1, 1'b0);
		plain_row("9", 1'b1, 1'b0);
		pinned_row(ctt_pkg::CH_EQ, 1'b1, 1'b0, ctt_pkg::TK_IDENT, 16'd1, 16'd3, 16'd1,
			8'h00);
		plain_row(ctt_pkg::CH_QUOTE, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_NL, 1'b1, 1'b0);
		plain_row("x", 1'b1, 1'b0);
		pinned_row(ctt_pkg::CH_QUOTE, 1'b1, 1'b0, ctt_pkg::TK_STRING, 16'd6, 16'd2, 16'd2,
			8'h00);
		plain_row(ctt_pkg::CH_DOT, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_COMMA, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_LPAR, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_RPAR, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_GT, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_RBRC, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_SPACE, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_TAB, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_CR, 1'b1, 1'b0);
		pinned_row(8'h80, 1'b1, 1'b0, ctt_pkg::TK_BAD, 16'd18, 16'd0, 16'd2, 8'h80);
		plain_row(8'hFF, 1'b1, 1'b0);
		plain_row(ctt_pkg::CH_NL, 1'b1, 1'b0);
		plain_row("k", 1'b1, 1'b0);
		// identifier closed by a byte that also ends the text: three tokens
		pinned_row(ctt_pkg::CH_RBRC, 1'b1, 1'b1, ctt_pkg::TK_IDENT, 16'd21, 16'd1, 16'd3,
			8'h00);
		pinned_row(8'h00, 1'b0, 1'b1, ctt_pkg::TK_END, 16'd0, 16'd0, 16'd1, 8'h00);
		plain_row(ctt_pkg::CH_QUOTE, 1'b1, 1'b0);
		// zero byte ends the open string
		pinned_row(ctt_pkg::CH_NUL, 1'b1, 1'b0, ctt_pkg::TK_UNTERM, 16'd1, 16'd0, 16'd1,
			8'h00);
		plain_row(8'h41, 1'b0, 1'b0);

		foreach (text_table[i]) begin
			offer(text_table[i].c, text_table[i].p, text_table[i].e, text_table[i].pinned,
				text_table[i].pin);
		end
		drain();

		// Random text
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent == RANDOM_ITEMS / 3) begin
				drain();
			end
			if (sent == RANDOM_ITEMS / 2) begin
				// long sink hold-off while the sender keeps pushing punctuation
				hold_requests = hold_requests + 1;
				steady_flow   = 1'b1;
				repeat (16) begin
					offer_plain(punct_byte(), 1'b1, 1'b0);
				end
				steady_flow = 1'b0;
				sent        = sent + 16;
			end
			random_item(c, p, e, counted);
			offer_plain(c, p, e);
			if (counted) begin
				sent = sent + 1;
			end
		end
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// Token sink and checker
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_LIMIT) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
			mismatches = mismatches + 1;
		end
	endtask

	task automatic check_token();
		token_rec_t want;
		if (expected_tokens.size() == 0) begin
			if (mismatches < REPORT_LIMIT) begin
				$display("%0t: token expected none got kind %0d offset %0h", $time,
					token_kind, content_offset);
			end
			mismatches = mismatches + 1;
			return;
		end
		want = expected_tokens.pop_front();
		check_field("token_kind", 16'(want.kind), 16'(token_kind));
		check_field("content_offset", want.offset, content_offset);
		check_field("content_length", want.length, content_length);
		check_field("line_number", want.line, line_number);
		check_field("offending_byte", 16'(want.bad), 16'(offending_byte));
		check_field("last_of_run", 16'(want.last), 16'(last_of_run));
	endtask

	initial begin : token_sink
		int stall_left;
		int holds_served;
		stall_left   = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (token_valid && token_ready) begin
				check_token();
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left   = LONG_HOLD;
			end
			// Next cycle's ready
			if (stall_left > 0) begin
				token_ready <= 1'b0;
				stall_left  = stall_left - 1;
			end else if (!steady_flow && arst_n && $urandom_range(0, 99) < 25) begin
				token_ready <= 1'b0;
				stall_left  = idle_gap();
			end else begin
				token_ready <= arst_n;
			end
		end
	end

	// Watchdog: too long with nothing moving on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (token_valid && token_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
